// ===== design/asrf_pkg.sv =====
`default_nettype none

package asrf_pkg;

   // fixed field widths of the block's ports
   localparam int FIELD_W   = 16;
   localparam int FILL_W    = 11;
   localparam int LEN_W     = 7;
   localparam int NUM_BUF_W = 5;

   // result queue in front of the rsp port
   localparam int RSP_DEPTH = 4;
   localparam int RSP_CNT_W = 3;
   localparam int RSP_PTR_W = 2;

   localparam logic [NUM_BUF_W-1:0] NUM_BUF_RESET = 5'd2;
   localparam logic [NUM_BUF_W-1:0] NUM_BUF_MIN   = 5'd1;

   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_TAKE = 1'b1;

   typedef enum logic [2:0] {
      ST_STORED   = 3'd0,
      ST_WAIT     = 3'd1,
      ST_OVERFLOW = 3'd2,
      ST_DATA     = 3'd3,
      ST_SILENCE  = 3'd4
   } status_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_TAKE = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      status_type          status;
      logic [FIELD_W-1:0]  left;
      logic [FIELD_W-1:0]  right;
      logic                last;
      logic [FILL_W-1:0]   fill;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== design/asrf_sample_mem.sv =====
`default_nettype none

module asrf_sample_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, updated only when rd_en is set
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/asrf_rsp_fifo.sv =====
`default_nettype none

module asrf_rsp_fifo (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  wire asrf_pkg::rsp_word_type          push_word,
   output logic      [asrf_pkg::RSP_CNT_W-1:0]  count,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output asrf_pkg::rsp_word_type               rsp_word
);

   import asrf_pkg::*;

   rsp_word_type          entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  head_ff, head_in;
   logic [RSP_PTR_W-1:0]  tail_ff, tail_in;
   logic [RSP_CNT_W-1:0]  count_ff, count_in;
   logic                  pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_word  = entry_ff[head_ff];
   assign count     = count_ff;

   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// ===== design/asrf_ctrl.sv =====
`default_nettype none

module asrf_ctrl #(
   parameter int STORE_DEPTH = 1024,
   parameter int MAX_CHUNK   = 64,
   parameter int STORED_W    = 16,
   parameter int ADDR_W      = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [asrf_pkg::NUM_BUF_W-1:0]    csr_num_buffers,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_type,
   input  wire logic                              req_chunk_start,
   input  wire logic signed [asrf_pkg::FIELD_W-1:0] req_in_left,
   input  wire logic signed [asrf_pkg::FIELD_W-1:0] req_in_right,
   input  wire logic [asrf_pkg::LEN_W-1:0]        req_take_length,
   output logic                                   mem_wr_en,
   output logic      [ADDR_W-1:0]                 mem_wr_addr,
   output logic      [2*STORED_W-1:0]             mem_wr_data,
   output logic                                   mem_rd_en,
   output logic      [ADDR_W-1:0]                 mem_rd_addr,
   input  wire logic [2*STORED_W-1:0]             mem_rd_data,
   input  wire logic [asrf_pkg::RSP_CNT_W-1:0]    fifo_count,
   output logic                                   fifo_push,
   output asrf_pkg::rsp_word_type                 fifo_word
);

   import asrf_pkg::*;

   localparam int                HELD_W    = $clog2(STORE_DEPTH + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
   localparam logic [HELD_W-1:0] FULL_CNT  = HELD_W'(STORE_DEPTH);
   localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_CHUNK);

   ctrl_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [HELD_W-1:0]       held_ff, held_in;
   logic [LEN_W-1:0]        last_len_ff, last_len_in;
   logic [NUM_BUF_W-1:0]    num_buf_ff, num_buf_in;
   logic [LEN_W-1:0]        remain_ff, remain_in;
   logic                    silent_ff, silent_in;
   logic                    pipe_valid_ff, pipe_valid_in;
   logic                    pipe_data_ff, pipe_data_in;
   rsp_word_type            pipe_word_ff, pipe_word_in;

   logic                    issue_ok;
   logic                    req_fire;
   logic [LEN_W-1:0]        take_len;
   logic [11:0]             wait_limit;

   // room in the result queue, counting the word in flight
   assign issue_ok   = (fifo_count + RSP_CNT_W'(pipe_valid_ff)) < RSP_CNT_W'(RSP_DEPTH);
   assign req_ready  = (state_ff == CS_IDLE) && issue_ok;
   assign req_fire   = req_valid && req_ready;
   assign take_len   = (req_take_length > LEN_MAX) ? LEN_MAX : req_take_length;
   assign wait_limit = 12'(num_buf_ff) * 12'(last_len_ff);

   assign mem_wr_addr = wr_ptr_ff;
   assign mem_rd_addr = rd_ptr_ff;
   assign mem_wr_data = {req_in_right[STORED_W-1:0], req_in_left[STORED_W-1:0]};

   assign num_buf_in = !csr_wr_en ? num_buf_ff
                     : (csr_num_buffers == '0) ? NUM_BUF_MIN : csr_num_buffers;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_fire && (req_type == REQ_TAKE) && (take_len != '0)) begin
               state_in = CS_TAKE;
            end
         end
         CS_TAKE: begin
            if (issue_ok && (remain_ff == LEN_W'(1))) begin
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // datapath and memory access
   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      held_in       = held_ff;
      last_len_in   = last_len_ff;
      remain_in     = remain_ff;
      silent_in     = silent_ff;
      pipe_valid_in = 1'b0;
      pipe_data_in  = pipe_data_ff;
      pipe_word_in  = pipe_word_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            if (req_fire && (req_type == REQ_PUT)) begin
               pipe_valid_in      = 1'b1;
               pipe_data_in       = 1'b0;
               pipe_word_in.left  = '0;
               pipe_word_in.right = '0;
               pipe_word_in.last  = 1'b1;
               if (req_chunk_start && (32'(held_ff) > 32'(wait_limit))) begin
                  pipe_word_in.status = ST_WAIT;
               end else if (held_ff >= FULL_CNT) begin
                  pipe_word_in.status = ST_OVERFLOW;
               end else begin
                  pipe_word_in.status = ST_STORED;
                  mem_wr_en = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + 1'b1;
                  held_in   = held_ff + 1'b1;
               end
            end else if (req_fire) begin
               last_len_in = take_len;
               remain_in   = take_len;
               silent_in   = 32'(take_len) > 32'(held_ff);
            end
         end
         CS_TAKE: begin
            if (issue_ok) begin
               pipe_valid_in      = 1'b1;
               remain_in          = remain_ff - 1'b1;
               pipe_word_in.left  = '0;
               pipe_word_in.right = '0;
               pipe_word_in.last  = (remain_ff == LEN_W'(1));
               if (silent_ff) begin
                  pipe_word_in.status = ST_SILENCE;
                  pipe_data_in        = 1'b0;
               end else begin
                  pipe_word_in.status = ST_DATA;
                  pipe_data_in        = 1'b1;
                  mem_rd_en = 1'b1;
                  rd_ptr_in = (rd_ptr_ff == LAST_ADDR) ? '0 : rd_ptr_ff + 1'b1;
                  held_in   = held_ff - 1'b1;
               end
            end
         end
         default: ;
      endcase
      if (pipe_valid_in) begin
         pipe_word_in.fill = FILL_W'(held_in);
      end
   end

   // read data lands together with the staged word
   always_comb begin
      fifo_push = pipe_valid_ff;
      fifo_word = pipe_word_ff;
      if (pipe_data_ff) begin
         fifo_word.left  = FIELD_W'(mem_rd_data[STORED_W-1:0]);
         fifo_word.right = FIELD_W'(mem_rd_data[2*STORED_W-1:STORED_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CS_IDLE;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         held_ff       <= '0;
         last_len_ff   <= '0;
         num_buf_ff    <= NUM_BUF_RESET;
         pipe_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         held_ff       <= held_in;
         last_len_ff   <= last_len_in;
         num_buf_ff    <= num_buf_in;
         pipe_valid_ff <= pipe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff    <= remain_in;
      silent_ff    <= silent_in;
      pipe_data_ff <= pipe_data_in;
      pipe_word_ff <= pipe_word_in;
   end

endmodule

`default_nettype wire

// ===== design/audio_sample_ring_fifo_top.sv =====
// Stereo sample ring FIFO. A put word stores one left/right sample pair, or is refused
// with a wait status (chunk start while the fill exceeds num_buffers times the last take
// length) or an overflow status (store full); either way it gives one result word. A take
// word asks for L samples (saturated to MAX_CHUNK) and gives L result words, stored data
// in order or silence when fewer than L are held; L of zero gives no result. Timing: a
// put is done once accepted; a take holds the request port while it latches the length
// and then reads one sample a cycle through the single read port of the sample memory,
// as long as the result buffer has room. Each result word is registered together with
// its memory read data, then written into the result buffer, and results queue in a four
// word buffer, so the request side keeps going while the consumer stalls until that
// buffer, counting the word in flight, is full. num_buffers is written through csr_wr_en/
// csr_num_buffers; the user must write it only while no word is in progress, as the
// block itself does not enforce this; a write of zero becomes one.
`default_nettype none

module audio_sample_ring_fifo_top #(
   parameter int STORE_DEPTH = 1024,
   parameter int MAX_CHUNK   = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_wr_en,
   input  wire logic [asrf_pkg::NUM_BUF_W-1:0]        csr_num_buffers,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_type,
   input  wire logic                                  req_chunk_start,
   input  wire logic signed [asrf_pkg::FIELD_W-1:0]   req_in_left,
   input  wire logic signed [asrf_pkg::FIELD_W-1:0]   req_in_right,
   input  wire logic [asrf_pkg::LEN_W-1:0]            req_take_length,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output asrf_pkg::status_type                       rsp_status,
   output logic signed [asrf_pkg::FIELD_W-1:0]        rsp_out_left,
   output logic signed [asrf_pkg::FIELD_W-1:0]        rsp_out_right,
   output logic                                       rsp_last,
   output logic      [asrf_pkg::FILL_W-1:0]           rsp_fill_level
);

   import asrf_pkg::*;

   // samples wider than the port field keep only the field's bits
   localparam int STORED_W = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
   localparam int ADDR_W   = $clog2(STORE_DEPTH);

   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [2*STORED_W-1:0]  mem_wr_data;
   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_rd_addr;
   logic [2*STORED_W-1:0]  mem_rd_data;
   logic [RSP_CNT_W-1:0]   fifo_count;
   logic                   fifo_push;
   rsp_word_type           fifo_word;
   rsp_word_type           rsp_word;

   // sequencer: put/take decisions, pointers, fill count, read staging
   asrf_ctrl #(
      .STORE_DEPTH (STORE_DEPTH),
      .MAX_CHUNK   (MAX_CHUNK),
      .STORED_W    (STORED_W),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_num_buffers (csr_num_buffers),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_chunk_start (req_chunk_start),
      .req_in_left     (req_in_left),
      .req_in_right    (req_in_right),
      .req_take_length (req_take_length),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data),
      .fifo_count      (fifo_count),
      .fifo_push       (fifo_push),
      .fifo_word       (fifo_word)
   );

   // sample ring, left in the low half, right in the high half
   asrf_sample_mem #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (2 * STORED_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // result buffer decouples the consumer from the sequencer
   asrf_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_word (fifo_word),
      .count     (fifo_count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_status     = rsp_word.status;
   assign rsp_out_left   = rsp_word.left;
   assign rsp_out_right  = rsp_word.right;
   assign rsp_last       = rsp_word.last;
   assign rsp_fill_level = rsp_word.fill;

endmodule

`default_nettype wire

// ===== design/asrf_checker.sv =====
`default_nettype none

module asrf_checker #(
   parameter int STORE_DEPTH = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire asrf_pkg::status_type                rsp_status,
   input  wire logic signed [asrf_pkg::FIELD_W-1:0] rsp_out_left,
   input  wire logic signed [asrf_pkg::FIELD_W-1:0] rsp_out_right,
   input  wire logic                                rsp_last,
   input  wire logic [asrf_pkg::FILL_W-1:0]         rsp_fill_level
);

   import asrf_pkg::*;

   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(STORE_DEPTH);

   logic                rsp_fire;
   logic                open_ff;
   status_type          prev_status_ff;
   logic [FILL_W-1:0]   prev_fill_ff;

   assign rsp_fire = rsp_valid && rsp_ready;

   // a take stream is open after a non-final take word
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else if (rsp_fire) begin
         open_ff <= !rsp_last && ((rsp_status == ST_DATA) || (rsp_status == ST_SILENCE));
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         prev_status_ff <= rsp_status;
         prev_fill_ff   <= rsp_fill_level;
      end
   end

   a_stream_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && open_ff) |->
         (rsp_status == prev_status_ff) &&
         ((rsp_status != ST_DATA) || (rsp_fill_level == prev_fill_ff - 1'b1)) &&
         ((rsp_status != ST_SILENCE) || (rsp_fill_level == prev_fill_ff)))
      else $error("take stream broken");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_DATA)) |->
         ((rsp_out_left == '0) && (rsp_out_right == '0)))
      else $error("non-data word carries sample");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_OVERFLOW)) |-> (rsp_fill_level == FULL_FILL))
      else $error("overflow while not full");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable({rsp_status, rsp_out_left, rsp_out_right,
                                rsp_last, rsp_fill_level})))
      else $error("stalled word changed");

endmodule

bind audio_sample_ring_fifo_top asrf_checker #(.STORE_DEPTH(STORE_DEPTH)) u_checker (.*);

`default_nettype wire
